### sv/lsbse_pkg.sv
// Package for the LSB steganography embed/extract block.
// Holds register indexes, status codes, mode codes and mask helpers.
// No dependencies.
package lsbse_pkg;

  localparam int unsigned BufferBits = 16;
  localparam int unsigned BufCntW    = $clog2(BufferBits + 1);
  localparam int unsigned LenW       = 24;
  localparam int unsigned BpcW       = 4;
  localparam int unsigned GatherW    = 16;
  localparam int unsigned GatherCntW = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 24;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 2'd0,
    REG_BPC  = 2'd1,
    REG_LEN  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_COVER = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_PASS  = 2'd3
  } status_e;

  // Low-bit mask of n ones, n in 0..8
  function automatic logic [BufferBits-1:0] buf_mask(input logic [BpcW-1:0] n);
    logic [BufferBits-1:0] one;
    one = {{(BufferBits-1){1'b0}}, 1'b1};
    return (one << n) - one;
  endfunction

  function automatic logic [7:0] byte_mask(input logic [BpcW-1:0] n);
    return (n >= BpcW'(8)) ? 8'hFF : ((8'h01 << n) - 8'h01);
  endfunction

endpackage

### sv/lsbse_req_if.sv
// Request channel of the LSB steganography block: valid/ready plus payload.
// Depends on lsbse_pkg.
interface lsbse_req_if
  import lsbse_pkg::*;
();
  logic    valid;
  logic    ready;
  action_e action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

### sv/lsbse_res_if.sv
// Result channel of the LSB steganography block: valid/ready plus payload.
// Depends on lsbse_pkg.
interface lsbse_res_if
  import lsbse_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  status_e    status;
  logic       last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

### sv/lsb_stego_embed_extract.sv
// Top level of the LSB steganography embedder/extractor.
// Depends on lsbse_pkg, lsbse_req_if, lsbse_res_if.
//
//  channel  | dir | payload                      | handshake
//  ---------+-----+------------------------------+------------------
//  req_i    | in  | action, data_byte            | valid/ready
//  res_o    | out | out_byte, status, last       | valid/ready
//  cfg      | in  | cfg_idx_i, cfg_data_i        | cfg_we_i only
//
// One request per cycle; its result sits in the output register the cycle
// after acceptance. The single output register sets the rate: req_i.ready is
// high whenever that register is empty or being drained in the same cycle.
// Loads and extract steps that produce no result simply do not fill it.
// rst_ni clears the stream state and the output valid and loads the register reset values.
module lsb_stego_embed_extract
  import lsbse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lsbse_req_if.sink           req_i,
  lsbse_res_if.source         res_o
);

  // Configuration registers
  mode_e           mode_q;
  logic [BpcW-1:0] bpc_q;
  logic [LenW-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EMBED;
      bpc_q  <= BpcW'(1);
      len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE: mode_q <= mode_e'(cfg_data_i[0]);
        REG_BPC:  bpc_q  <= cfg_data_i[BpcW-1:0];
        REG_LEN:  len_q  <= cfg_data_i[LenW-1:0];
        default:  ;
      endcase
    end
  end

  // Stream state
  logic [BufferBits-1:0] buf_q, buf_d;
  logic [BufCntW-1:0]    bcnt_q, bcnt_d;
  logic [LenW-1:0]       done_q, done_d;
  logic [GatherW-1:0]    gath_q, gath_d;
  logic [GatherCntW-1:0] gcnt_q, gcnt_d;

  // Output register
  logic       res_valid_q, res_valid_d;
  logic [7:0] res_byte_q, res_byte_d;
  status_e    res_status_q, res_status_d;
  logic       res_last_q, res_last_d;

  logic accept;
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Step logic
  logic [BpcW-1:0]       bpc;
  logic [LenW-1:0]       remaining;
  logic [BpcW-1:0]       n;
  logic                  ended;
  logic [LenW-1:0]       done_inc;
  logic [7:0]            sec_bits;
  logic [GatherW-1:0]    gath_sum;
  logic [GatherCntW-1:0] gcnt_sum;
  logic                  step_valid;
  logic [7:0]            step_byte;
  status_e               step_status;
  logic                  step_last;

  always_comb begin
    // clamp bits per channel to 1..8
    if (bpc_q == '0) begin
      bpc = BpcW'(1);
    end else if (bpc_q > BpcW'(8)) begin
      bpc = BpcW'(8);
    end else begin
      bpc = bpc_q;
    end
    ended     = (done_q >= len_q);
    remaining = len_q - done_q;
    n         = (remaining < LenW'(bpc)) ? remaining[BpcW-1:0] : bpc;
    done_inc  = done_q + LenW'(n);
    sec_bits  = buf_q[7:0] & byte_mask(n);
    gath_sum  = gath_q | (GatherW'(req_i.data_byte & byte_mask(n)) << gcnt_q);
    gcnt_sum  = gcnt_q + GatherCntW'(n);

    buf_d       = buf_q;
    bcnt_d      = bcnt_q;
    done_d      = done_q;
    gath_d      = gath_q;
    gcnt_d      = gcnt_q;
    step_valid  = 1'b0;
    step_byte   = req_i.data_byte;
    step_status = ST_OK;
    step_last   = 1'b0;

    if (req_i.action == ACT_LOAD) begin
      // secret byte load
      if (mode_q == MODE_EMBED) begin
        if (BufCntW'(bcnt_q + BufCntW'(8)) > BufCntW'(BufferBits)
            || bcnt_q > BufCntW'(BufferBits - 8)) begin
          step_valid  = 1'b1;
          step_byte   = '0;
          step_status = ST_FULL;
        end else begin
          buf_d  = buf_q | (BufferBits'(req_i.data_byte) << bcnt_q);
          bcnt_d = bcnt_q + BufCntW'(8);
        end
      end
    end else if (mode_q == MODE_EMBED) begin
      // embed into cover byte
      step_valid = 1'b1;
      if (ended) begin
        step_status = ST_PASS;
      end else begin
        if (bcnt_q < BufCntW'(n)) begin
          step_status = ST_SHORT;
          buf_d       = '0;
          bcnt_d      = '0;
        end else begin
          buf_d  = buf_q >> n;
          bcnt_d = bcnt_q - BufCntW'(n);
        end
        done_d    = done_inc;
        step_byte = (req_i.data_byte & ~byte_mask(bpc)) | sec_bits;
        step_last = (done_inc == len_q);
      end
    end else begin
      // extract from cover byte
      if (ended) begin
        if (gcnt_q != '0) begin
          step_valid = 1'b1;
          step_byte  = gath_q[7:0];
          step_last  = 1'b1;
          gath_d     = '0;
          gcnt_d     = '0;
        end
      end else begin
        done_d = done_inc;
        if (gcnt_sum >= GatherCntW'(8)) begin
          step_valid = 1'b1;
          step_byte  = gath_sum[7:0];
          gath_d     = gath_sum >> 8;
          gcnt_d     = gcnt_sum - GatherCntW'(8);
          step_last  = (done_inc == len_q) && (gcnt_d == '0);
        end else if (done_inc == len_q) begin
          step_valid = 1'b1;
          step_byte  = gath_sum[7:0];
          step_last  = 1'b1;
          gath_d     = '0;
          gcnt_d     = '0;
        end else begin
          gath_d = gath_sum;
          gcnt_d = gcnt_sum;
        end
      end
    end
  end

  // Output register next values
  always_comb begin
    res_valid_d  = res_valid_q && !res_o.ready;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    if (accept) begin
      res_valid_d = step_valid;
      if (step_valid) begin
        res_byte_d   = step_byte;
        res_status_d = step_status;
        res_last_d   = step_last;
      end
    end
  end

  // State and output register update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      bcnt_q      <= '0;
      done_q      <= '0;
      gath_q      <= '0;
      gcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (accept) begin
        buf_q  <= buf_d;
        bcnt_q <= bcnt_d;
        done_q <= done_d;
        gath_q <= gath_d;
        gcnt_q <= gcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.out_byte = res_byte_q;
  assign res_o.status   = res_status_q;
  assign res_o.last     = res_last_q;

`ifndef SYNTHESIS
  // buffer fill never exceeds its capacity
  a_bcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BufCntW'(BufferBits))
    else $error("bit buffer count over capacity");

  // leftover gathered bits are always less than a byte
  a_gcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcnt_q < GatherCntW'(8))
    else $error("gather count holds a full byte");

  // a rejected load reports a zero byte that is never last
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == ST_FULL) |-> (res_o.out_byte == 8'h00 && !res_o.last))
    else $error("bad buffer-full result");

  // an accepted embed load grows the buffer by one byte
  a_load_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ACT_LOAD && mode_q == MODE_EMBED
     && bcnt_q <= BufCntW'(BufferBits - 8))
    |=> (bcnt_q == $past(bcnt_q) + BufCntW'(8)))
    else $error("load did not grow bit buffer");
`endif

endmodule
